>>> hw/rtl/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg
// Shared types, constants and the arctangent table of the axis-angle rotator.
// ----------------------------------------------------------------------------
package avr_pkg;

  // Number of CORDIC micro-rotations, one chain cell each (8 to 31).
  localparam int CORDIC_STEPS = 16;

  // Internal word width of the setup arithmetic (Q.30 with headroom).
  localparam int CW = 36;
  // Width of one scaled matrix-vector product term.
  localparam int PW = 58;
  // Step index width of a CORDIC cell.
  localparam int STEP_W = 5;

  // Iteration counts of the setup sequencer.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 62;
  localparam int MUL_STEPS  = 15;

  localparam logic signed [CW-1:0] ONE_Q30     = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(64'sd1686629713);
  localparam logic signed [CW-1:0] PI_Q30      = CW'(64'sd3373259426);
  localparam logic signed [CW-1:0] TWO_PI_Q30  = CW'(64'sd6746518852);
  localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);

  typedef enum logic [1:0] {
    REG_AXIS_X = 2'd0,
    REG_AXIS_Y = 2'd1,
    REG_AXIS_Z = 2'd2,
    REG_ANGLE  = 2'd3
  } reg_e;

  // Data handed from one CORDIC cell to the next.
  typedef struct packed {
    logic          vld;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } cord_t;

  // Status and rotation matrix from the setup engine to the datapath.
  typedef struct packed {
    logic               busy;
    logic               axis_zero;
    logic [8:0][CW-1:0] r;
  } setup_t;

  function automatic logic [CW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      5'd24:   v = 32'h0000003F;
      5'd25:   v = 32'h0000001F;
      5'd26:   v = 32'h0000000F;
      5'd27:   v = 32'h00000008;
      5'd28:   v = 32'h00000004;
      5'd29:   v = 32'h00000002;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return {{(CW-32){1'b0}}, v};
  endfunction

endpackage

>>> hw/rtl/avr_cordic_cell.sv
// ----------------------------------------------------------------------------
// avr_cordic_cell
// One registered CORDIC micro-rotation in rotation mode.
// ----------------------------------------------------------------------------
module avr_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [avr_pkg::STEP_W-1:0]  step_i,
  input  avr_pkg::cord_t              cell_i,
  output avr_pkg::cord_t              cell_o
);

  logic signed [avr_pkg::CW-1:0] x, y, z, xs, ys, at;
  logic signed [avr_pkg::CW-1:0] x_d, y_d, z_d;
  logic signed [avr_pkg::CW-1:0] x_q, y_q, z_q;
  logic                          vld_q;

  always_comb begin
    x  = $signed(cell_i.x);
    y  = $signed(cell_i.y);
    z  = $signed(cell_i.z);
    xs = x >>> step_i;
    ys = y >>> step_i;
    at = $signed(avr_pkg::atan_q30(step_i));
    if (!z[avr_pkg::CW-1]) begin
      x_d = x - ys;
      y_d = y + xs;
      z_d = z - at;
    end else begin
      x_d = x + ys;
      y_d = y - xs;
      z_d = z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign cell_o = '{vld: vld_q, x: x_q, y: y_q, z: z_q};

endmodule

>>> hw/rtl/avr_setup.sv
// ----------------------------------------------------------------------------
// avr_setup
// Builds the rotation matrix from the axis and angle registers.
// ----------------------------------------------------------------------------
module avr_setup (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [31:0]           axis_x_i,
  input  logic [31:0]           axis_y_i,
  input  logic [31:0]           axis_z_i,
  input  logic [19:0]           angle_i,
  output avr_pkg::setup_t       setup_o
);

  localparam int CW = avr_pkg::CW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_NORM, ST_SQ, ST_SQRT, ST_DIV, ST_ANG, ST_CORD, ST_MUL, ST_BUILD
  } state_e;

  state_e      state_q;
  logic [5:0]  cnt_q;
  logic [1:0]  comp_q;
  logic        az_q;

  logic [31:0]          axis [3];
  logic [31:0]          abs_v [3];
  logic [31:0]          mag_q [3];
  logic [2:0]           sgn_q;
  logic [63:0]          sum_q, res_q, bit_q;
  logic [31:0]          len_q, rem_q;
  logic [61:0]          dq_q;
  logic signed [CW-1:0] n_q [3];
  logic signed [CW-1:0] t_q, c_q, s_q, w_q, nn_q;
  logic signed [CW-1:0] prod_q [9];
  logic                 neg_q;
  logic [8:0][CW-1:0]   r_q;

  logic                 zero_axis, norm_done;
  logic signed [CW-1:0] t_raw, t_red, f_z, c_val;
  logic                 f_neg;
  logic [63:0]          sq_p, sq_t, res_nx;
  logic                 sq_ge;
  logic [32:0]          dr, d_sub;
  logic                 d_ge;
  logic [61:0]          dq_nx;
  logic [1:0]           comp_nx;
  logic signed [CW-1:0] n_new;
  logic signed [CW-1:0] mul_a, mul_b;
  logic signed [2*CW-1:0] mul_p;
  logic [3:0]           mul_k, mul_dst;

  avr_pkg::cord_t chain [avr_pkg::CORDIC_STEPS+1];

  always_comb begin
    axis[0] = axis_x_i;
    axis[1] = axis_y_i;
    axis[2] = axis_z_i;
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = axis[i][31] ? (~axis[i] + 32'd1) : axis[i];
    end
    zero_axis = (axis_x_i == 32'd0) && (axis_y_i == 32'd0) && (axis_z_i == 32'd0);
    norm_done = (mag_q[0][31:30] != 2'b00) || (mag_q[1][31:30] != 2'b00) ||
                (mag_q[2][31:30] != 2'b00);

    // Angle to Q.30 and one wrap into [-pi, pi].
    t_raw = $signed({{(CW-34){angle_i[19]}}, angle_i, 14'b0});
    if (t_raw > avr_pkg::PI_Q30) begin
      t_red = t_raw - avr_pkg::TWO_PI_Q30;
    end else if (t_raw < -avr_pkg::PI_Q30) begin
      t_red = t_raw + avr_pkg::TWO_PI_Q30;
    end else begin
      t_red = t_raw;
    end
    // Fold into [-pi/2, pi/2]; the cosine flips sign when folded.
    if (t_q > avr_pkg::HALF_PI_Q30) begin
      f_z   = avr_pkg::PI_Q30 - t_q;
      f_neg = 1'b1;
    end else if (t_q < -avr_pkg::HALF_PI_Q30) begin
      f_z   = -avr_pkg::PI_Q30 - t_q;
      f_neg = 1'b1;
    end else begin
      f_z   = t_q;
      f_neg = 1'b0;
    end

    sq_p   = mag_q[comp_q] * mag_q[comp_q];
    sq_t   = res_q + bit_q;
    sq_ge  = sum_q >= sq_t;
    res_nx = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

    dr      = {rem_q, dq_q[61]};
    d_ge    = dr >= {1'b0, len_q};
    d_sub   = dr - {1'b0, len_q};
    dq_nx   = {dq_q[60:0], d_ge};
    comp_nx = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
    n_new   = sgn_q[comp_q] ? ($signed(CW'(0)) - $signed({{(CW-31){1'b0}}, dq_nx[30:0]}))
                            : $signed({{(CW-31){1'b0}}, dq_nx[30:0]});

    c_val = neg_q ? -$signed(chain[avr_pkg::CORDIC_STEPS].x)
                  : $signed(chain[avr_pkg::CORDIC_STEPS].x);

    mul_k = cnt_q[3:0];
    case (mul_k)
      4'd0:    begin mul_a = n_q[0]; mul_b = n_q[0]; end
      4'd2:    begin mul_a = n_q[0]; mul_b = n_q[1]; end
      4'd4:    begin mul_a = n_q[0]; mul_b = n_q[2]; end
      4'd6:    begin mul_a = n_q[1]; mul_b = n_q[1]; end
      4'd8:    begin mul_a = n_q[1]; mul_b = n_q[2]; end
      4'd10:   begin mul_a = n_q[2]; mul_b = n_q[2]; end
      4'd12:   begin mul_a = n_q[0]; mul_b = s_q; end
      4'd13:   begin mul_a = n_q[1]; mul_b = s_q; end
      4'd14:   begin mul_a = n_q[2]; mul_b = s_q; end
      default: begin mul_a = nn_q;   mul_b = w_q; end
    endcase
    mul_p   = mul_a * mul_b;
    mul_dst = (mul_k >= 4'd12) ? (mul_k - 4'd6) : (mul_k >> 1);
  end

  assign chain[0] = '{vld: (state_q == ST_ANG), x: avr_pkg::GAIN_Q30, y: '0, z: f_z};

  for (genvar k = 0; k < avr_pkg::CORDIC_STEPS; k++) begin : g_cell
    avr_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (avr_pkg::STEP_W'(k)),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      comp_q  <= '0;
      az_q    <= 1'b0;
    end else if (start_i) begin
      state_q <= ST_LOAD;
      az_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (zero_axis) begin
            az_q    <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (norm_done) begin
            state_q <= ST_SQ;
            comp_q  <= '0;
          end
        end
        ST_SQ: begin
          comp_q <= comp_nx;
          if (comp_q == 2'd2) begin
            state_q <= ST_SQRT;
            cnt_q   <= '0;
          end
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(avr_pkg::SQRT_STEPS - 1)) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
            comp_q  <= '0;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(avr_pkg::DIV_STEPS - 1)) begin
            cnt_q  <= '0;
            comp_q <= comp_nx;
            if (comp_q == 2'd2) begin
              state_q <= ST_ANG;
            end
          end
        end
        ST_ANG: state_q <= ST_CORD;
        ST_CORD: begin
          if (chain[avr_pkg::CORDIC_STEPS].vld) begin
            state_q <= ST_MUL;
            cnt_q   <= '0;
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(avr_pkg::MUL_STEPS - 1)) begin
            state_q <= ST_BUILD;
          end
        end
        ST_BUILD: state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= abs_v[i];
          sgn_q[i] <= axis[i][31];
        end
        t_q   <= t_red;
        sum_q <= '0;
      end
      ST_NORM: begin
        if (!norm_done) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] << 1;
          end
        end
      end
      ST_SQ: begin
        sum_q <= sum_q + sq_p;
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sum_q <= sum_q - sq_t;
        end
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        len_q <= res_nx[31:0];
        rem_q <= '0;
        dq_q  <= {mag_q[0], 30'b0};
      end
      ST_DIV: begin
        rem_q <= d_ge ? d_sub[31:0] : dr[31:0];
        dq_q  <= dq_nx;
        if (cnt_q == 6'(avr_pkg::DIV_STEPS - 1)) begin
          n_q[comp_q] <= n_new;
          rem_q       <= '0;
          dq_q        <= {mag_q[comp_nx], 30'b0};
        end
      end
      ST_ANG: neg_q <= f_neg;
      ST_CORD: begin
        c_q <= c_val;
        s_q <= $signed(chain[avr_pkg::CORDIC_STEPS].y);
        w_q <= avr_pkg::ONE_Q30 - c_val;
      end
      ST_MUL: begin
        if (mul_k < 4'd12 && !mul_k[0]) begin
          nn_q <= mul_p[CW+29:30];
        end else begin
          prod_q[mul_dst] <= mul_p[CW+29:30];
        end
      end
      ST_BUILD: begin
        r_q[0] <= c_q + prod_q[0];
        r_q[1] <= prod_q[1] - prod_q[8];
        r_q[2] <= prod_q[2] + prod_q[7];
        r_q[3] <= prod_q[1] + prod_q[8];
        r_q[4] <= c_q + prod_q[3];
        r_q[5] <= prod_q[4] - prod_q[6];
        r_q[6] <= prod_q[2] - prod_q[7];
        r_q[7] <= prod_q[4] + prod_q[6];
        r_q[8] <= c_q + prod_q[5];
      end
      default: ;
    endcase
  end

  assign setup_o = '{busy: (state_q != ST_IDLE), axis_zero: az_q, r: r_q};

endmodule

>>> hw/rtl/avr_apply.sv
// ----------------------------------------------------------------------------
// avr_apply
// Three-stage stream datapath: matrix times vector, round and saturate; a zero axis passes the vector through.
// ----------------------------------------------------------------------------
module avr_apply (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  avr_pkg::setup_t setup_i,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [95:0]     s_data_i,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic [95:0]     m_data_o,
  output logic [1:0]      m_user_o
);

  localparam int CW = avr_pkg::CW;
  localparam int PW = avr_pkg::PW;

  logic        v0_q, v1_q, v2_q;
  logic        rdy0, rdy1, rdy2, acc_in;
  logic [95:0] vec0_q, vec1_q, out_q;
  logic [1:0]  user_q;
  logic signed [PW-1:0] p1_q [9];
  logic signed [PW-1:0] p_d [9];
  logic signed [2*CW-1:0] prod [9];
  logic signed [PW+1:0]  sum [3];
  logic signed [PW+1:0]  rnd [3];
  logic signed [43:0]    acc [3];
  logic [31:0]           sat [3];
  logic [2:0]            clip;

  assign rdy2      = !v2_q || m_ready_i;
  assign rdy1      = !v1_q || rdy2;
  assign rdy0      = !v0_q || rdy1;
  assign s_ready_o = rdy0 && !setup_i.busy;
  assign acc_in    = s_valid_i && s_ready_o;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[3*i+j] = $signed(setup_i.r[3*i+j]) *
                      $signed({{(CW-32){vec0_q[32*j+31]}}, vec0_q[32*j +: 32]});
        p_d[3*i+j]  = prod[3*i+j][PW+13:14];
      end
    end
    for (int i = 0; i < 3; i++) begin
      sum[i]  = PW'(0) + {{2{p1_q[3*i][PW-1]}}, p1_q[3*i]} +
                {{2{p1_q[3*i+1][PW-1]}}, p1_q[3*i+1]} +
                {{2{p1_q[3*i+2][PW-1]}}, p1_q[3*i+2]};
      rnd[i]  = sum[i] + (PW+2)'(32768);
      acc[i]  = rnd[i][59:16];
      if (!acc[i][43] && (acc[i][42:31] != 12'd0)) begin
        sat[i]  = 32'h7FFF_FFFF;
        clip[i] = 1'b1;
      end else if (acc[i][43] && (acc[i][42:31] != 12'hFFF)) begin
        sat[i]  = 32'h8000_0000;
        clip[i] = 1'b1;
      end else begin
        sat[i]  = acc[i][31:0];
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= acc_in;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      vec0_q <= s_data_i;
    end
    if (rdy1 && v0_q) begin
      vec1_q <= vec0_q;
      for (int k = 0; k < 9; k++) begin
        p1_q[k] <= p_d[k];
      end
    end
    if (rdy2 && v1_q) begin
      if (setup_i.axis_zero) begin
        out_q  <= vec1_q;
        user_q <= 2'b01;
      end else begin
        out_q  <= {sat[2], sat[1], sat[0]};
        user_q <= {|clip, 1'b0};
      end
    end
  end

  assign m_valid_o = v2_q;
  assign m_data_o  = out_q;
  assign m_user_o  = user_q;

endmodule

>>> hw/rtl/axis_angle_vector_rotate_top.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_top
// Rotates a stream of Q16.16 vectors about a configured axis by an angle.
// ----------------------------------------------------------------------------
// Each vector is registered in turn in the input register, the product register
// and the output register; any of them can hold it while the output waits.
// Throughput: one vector per cycle while the output is ready and the setup
// engine is idle, set by the three-stage multiply pipeline. After reset and
// after every register write the setup engine rebuilds the matrix (the three
// divisions dominate); the stream input is held not ready meanwhile.
// Reset (rst_ni, asynchronous, active low) loads axis (0,0,1) and angle 0.

module axis_angle_vector_rotate_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input vector beats.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
  // Rotated vector beats.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // rot_x [31:0], rot_y [63:32], rot_z [95:64]
  output logic [1:0]  m_axis_tuser    // axis_zero [0], clipped [1]
);

  logic [31:0]     axis_x_q, axis_y_q, axis_z_q;
  logic [19:0]     angle_q;
  logic            wr_en;
  avr_pkg::reg_e   reg_sel;
  avr_pkg::setup_t setup;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = avr_pkg::reg_e'(paddr[3:2]);

  // Register file. A write restarts the setup engine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q <= 32'd0;
      axis_y_q <= 32'd0;
      axis_z_q <= 32'd65536;
      angle_q  <= 20'd0;
    end else if (wr_en) begin
      case (reg_sel)
        avr_pkg::REG_AXIS_X: axis_x_q <= pwdata;
        avr_pkg::REG_AXIS_Y: axis_y_q <= pwdata;
        avr_pkg::REG_AXIS_Z: axis_z_q <= pwdata;
        avr_pkg::REG_ANGLE:  angle_q  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored value, the angle sign-extended.
  always_comb begin
    case (reg_sel)
      avr_pkg::REG_AXIS_X: prdata = axis_x_q;
      avr_pkg::REG_AXIS_Y: prdata = axis_y_q;
      avr_pkg::REG_AXIS_Z: prdata = axis_z_q;
      avr_pkg::REG_ANGLE:  prdata = {{12{angle_q[19]}}, angle_q};
      default:             prdata = 32'd0;
    endcase
  end

  // Setup engine: normalizes the axis, runs the CORDIC cell chain and forms
  // the nine matrix entries with one shared multiplier.
  avr_setup u_setup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wr_en),
    .axis_x_i (axis_x_q),
    .axis_y_i (axis_y_q),
    .axis_z_i (axis_z_q),
    .angle_i  (angle_q),
    .setup_o  (setup)
  );

  // Streaming datapath with per-stage flow control, so an empty stage keeps
  // filling while the output register waits.
  avr_apply u_apply (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .setup_i   (setup),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser)
  );

  // A register write must take the stream input not ready right after it; only that first point is checked.
  a_write_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> !s_axis_tready)
    else $error("input ready right after a register write");

  // A passed-through vector never reports saturation.
  a_zero_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
    else $error("axis_zero and clipped both set");

  // Saturation is flagged only when some component sits at a limit.
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000 ||
       m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000 ||
       m_axis_tdata[95:64] == 32'h7FFF_FFFF || m_axis_tdata[95:64] == 32'h8000_0000))
    else $error("clipped set without a saturated component");

endmodule
